// ===== sv/aodv_pkg.sv =====
// Shared types, codes and helper functions for the route message handler.
`default_nettype none
package aodv_pkg;

	localparam int ID_W = 5;
	localparam int PREC_MAX = 16;

	localparam logic [2:0] OP_DATA = 3'd0;
	localparam logic [2:0] OP_RREQ = 3'd1;
	localparam logic [2:0] OP_RREP = 3'd2;
	localparam logic [2:0] OP_RERR = 3'd3;
	localparam logic [2:0] OP_HELLO = 3'd4;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_DELIVER = 3'd1;
	localparam logic [2:0] ACT_FWD_DATA = 3'd2;
	localparam logic [2:0] ACT_SEND_REP = 3'd3;
	localparam logic [2:0] ACT_REBCAST = 3'd4;
	localparam logic [2:0] ACT_FWD_REP = 3'd5;
	localparam logic [2:0] ACT_ESTAB = 3'd6;
	localparam logic [2:0] ACT_SEND_ERR = 3'd7;

	localparam logic CFG_MY_NODE = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic valid;
		logic [ID_W-1:0] next_hop;
		logic [7:0] hops;
		logic [31:0] seq;
		logic [31:0] expiry;
		logic [PREC_MAX-1:0] prec;
	} route_row_t;

	typedef struct packed {
		logic [15:0] req_id;
		logic [31:0] seq;
	} node_row_t;

	// Precursor mask bit for node id; ids outside the table give no bit.
	function automatic logic [PREC_MAX-1:0] prec_bit(logic [ID_W-1:0] id, int unsigned nodes);
		logic [PREC_MAX-1:0] r;
		r = '0;
		if (id != '0 && 32'(id) <= nodes && 32'(id) <= PREC_MAX)
			r = PREC_MAX'(1) << (id - ID_W'(1));
		return r;
	endfunction

	function automatic logic [31:0] max32(logic [31:0] a, logic [31:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

// ===== sv/aodv_route_message_handler.sv =====
// Top level of the route message handler: control sequencer and table update logic.
// A data, request or reply word reads the origin row, then the target row, executes and
// writes the target row back; busy holds off a new word until then, as both rows come through
// one read port of the route memory. A route error then sends an error word per precursor.
// Hello words and words that are ignored leave busy low and cause no table change.
// Reset clears control state and all table written flags, so tables read as zero at once.
// Results appear for one cycle with done high; the receiver cannot stall them.
`default_nettype none
module aodv_route_message_handler import aodv_pkg::*; #(
	parameter int NODES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_wdata,
	input wire logic [2:0] opcode,
	input wire logic [31:0] now,
	input wire logic [4:0] sender,
	input wire logic [4:0] origin,
	input wire logic [4:0] target,
	input wire logic [15:0] request_id,
	input wire logic [31:0] origin_seq,
	input wire logic [31:0] target_seq,
	input wire logic [7:0] hop_count,
	input wire logic [31:0] route_life,
	output logic done,
	output logic [2:0] action,
	output logic [4:0] next_node,
	output logic [4:0] msg_origin,
	output logic [4:0] msg_target,
	output logic [31:0] msg_seq,
	output logic [7:0] msg_hops,
	output logic [31:0] msg_life,
	output logic last
);

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int RW = $bits(route_row_t);
	localparam int NW = $bits(node_row_t);

	// Sequencer states: read origin row, read target row, execute, write target, errors.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RO = 3'd1;
	localparam logic [2:0] ST_RT = 3'd2;
	localparam logic [2:0] ST_EX = 3'd3;
	localparam logic [2:0] ST_WT = 3'd4;
	localparam logic [2:0] ST_ER = 3'd5;

	logic [2:0] state_q;

	logic [4:0] my_node_q;
	logic [31:0] timeout_q;

	// Latched message word.
	logic [2:0] op_q;
	logic [31:0] now_q;
	logic [4:0] snd_q, org_q, tgt_q;
	logic [15:0] rid_q;
	logic [31:0] oseq_q, tseq_q, life_q;
	logic [7:0] hop_q;
	logic [IW-1:0] oi_q, ti_q;

	route_row_t ro_q, rt_q;
	node_row_t no_q, nt_q;

	// Target-row write-back and error scan state.
	route_row_t wb_route_q;
	node_row_t wb_node_q;
	logic wb_route_en_q, wb_node_en_q, err_go_q;
	logic [PREC_MAX-1:0] err_mask_q;
	logic [31:0] err_seq_q;

	logic [RW-1:0] route_rd;
	logic [NW-1:0] node_rd;
	logic [IW-1:0] rd_addr, wr_addr;
	logic route_we, node_we;
	logic [RW-1:0] route_wd;
	logic [NW-1:0] node_wd;

	function automatic logic id_ok(logic [4:0] id);
		return id != 5'd0 && 32'(id) <= NODES;
	endfunction

	function automatic logic [IW-1:0] to_idx(logic [4:0] id);
		logic [4:0] d;
		d = id - 5'd1;
		return IW'(d);
	endfunction

	// Words with bad node ids, hello words and requests from this node are dropped at the door.
	logic in_take;
	always_comb begin
		in_take = 1'b0;
		case (opcode)
			OP_DATA, OP_RREP: in_take = id_ok(origin) && id_ok(target);
			OP_RREQ: in_take = id_ok(origin) && id_ok(target) && origin != my_node_q;
			OP_RERR: in_take = id_ok(target);
			default: in_take = 1'b0;
		endcase
	end

	logic accept;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign rd_addr = (state_q == ST_IDLE) ? to_idx(origin) : ti_q;

	aodv_mem #(.W(RW), .DEPTH(NODES)) u_route (
		.clk(clk), .arst_n(arst_n),
		.rd_addr(rd_addr), .rd_data(route_rd),
		.wr_en(route_we), .wr_addr(wr_addr), .wr_data(route_wd)
	);

	aodv_mem #(.W(NW), .DEPTH(NODES)) u_node (
		.clk(clk), .arst_n(arst_n),
		.rd_addr(rd_addr), .rd_data(node_rd),
		.wr_en(node_we), .wr_addr(wr_addr), .wr_data(node_wd)
	);

	// Execute step: apply the message to copies of both rows in model order. When origin
	// and target name the same node, each update is mirrored so the later write is complete.
	route_row_t a, b;
	node_row_t na, nb;
	logic wa, wb, wna, wnb, emit, err_go, alias_e, prop;
	logic [2:0] e_act;
	logic [4:0] e_next, e_org, e_tgt;
	logic [31:0] e_seq, e_life, expire, rem;
	logic [7:0] e_hops, nh;

	always_comb begin
		a = ro_q;
		b = rt_q;
		na = no_q;
		nb = nt_q;
		wa = 1'b0;
		wb = 1'b0;
		wna = 1'b0;
		wnb = 1'b0;
		emit = 1'b0;
		err_go = 1'b0;
		prop = 1'b0;
		rem = '0;
		e_act = ACT_NONE;
		e_next = '0;
		e_org = org_q;
		e_tgt = tgt_q;
		e_seq = '0;
		e_hops = '0;
		e_life = '0;
		alias_e = (oi_q == ti_q);
		nh = (hop_q == 8'hFF) ? 8'hFF : hop_q + 8'd1;
		expire = now_q + timeout_q;
		case (op_q)
			OP_DATA: begin
				a.expiry = expire;
				wa = 1'b1;
				if (alias_e) b = a;
				emit = 1'b1;
				if (tgt_q == my_node_q) begin
					e_act = ACT_DELIVER;
				end else begin
					b.expiry = expire;
					wb = 1'b1;
					e_act = ACT_FWD_DATA;
					e_next = b.next_hop;
				end
			end
			OP_RREQ: begin
				if (rid_q > na.req_id) begin
					na.req_id = rid_q;
					wna = 1'b1;
					if (alias_e) nb = na;
					if (!a.valid) begin
						a.seq = oseq_q;
						a.prec = '0;
					end else begin
						a.seq = max32(a.seq, oseq_q);
					end
					a.next_hop = snd_q;
					a.hops = nh;
					a.expiry = expire;
					a.valid = 1'b1;
					wa = 1'b1;
					if (alias_e) b = a;
					emit = 1'b1;
					if (tgt_q == my_node_q) begin
						if (nb.seq + 32'd1 == oseq_q) begin
							nb.seq = nb.seq + 32'd1;
							wnb = 1'b1;
						end
						e_act = ACT_SEND_REP;
						e_next = snd_q;
						e_seq = max32(nb.seq, tseq_q);
						e_life = timeout_q;
					end else if (b.valid) begin
						rem = (b.expiry > now_q) ? b.expiry - now_q : 32'd0;
						b.prec = b.prec | prec_bit(snd_q, NODES);
						wb = 1'b1;
						e_act = ACT_SEND_REP;
						e_next = snd_q;
						e_seq = b.seq;
						e_hops = b.hops;
						e_life = rem;
					end else begin
						e_act = ACT_REBCAST;
						e_seq = max32(nb.seq, tseq_q);
						e_hops = nh;
					end
				end
			end
			OP_RREP: begin
				if (!b.valid) begin
					b.prec = '0;
					prop = 1'b1;
				end else if (tseq_q > b.seq || (tseq_q == b.seq && nh < b.hops)) begin
					prop = 1'b1;
				end
				if (prop) begin
					b.next_hop = snd_q;
					b.hops = nh;
					b.seq = tseq_q;
					b.expiry = now_q + life_q;
					b.valid = 1'b1;
					wb = 1'b1;
					if (alias_e) a = b;
				end
				if (org_q == my_node_q) begin
					emit = 1'b1;
					e_act = ACT_ESTAB;
				end else if (prop) begin
					a.expiry = now_q + life_q;
					a.prec = a.prec | prec_bit(snd_q, NODES);
					wa = 1'b1;
					if (alias_e) b = a;
					b.prec = b.prec | prec_bit(a.next_hop, NODES);
					emit = 1'b1;
					e_act = ACT_FWD_REP;
					e_next = a.next_hop;
					e_seq = tseq_q;
					e_hops = nh;
					e_life = life_q;
				end
			end
			OP_RERR: begin
				if (b.valid && b.next_hop == snd_q) begin
					b.valid = 1'b0;
					wb = 1'b1;
					err_go = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Lowest pending precursor for the error scan, one error word per cycle.
	logic [PREC_MAX-1:0] low_bit, rest_mask;
	logic [4:0] low_idx;
	always_comb begin
		low_bit = err_mask_q & (~err_mask_q + PREC_MAX'(1));
		rest_mask = err_mask_q & ~low_bit;
		low_idx = '0;
		for (int i = 0; i < PREC_MAX; i++) begin
			if (low_bit[i])
				low_idx = 5'(i);
		end
	end

	// Origin row is written in the execute state, target row in the write-target state after it.
	always_comb begin
		route_we = 1'b0;
		node_we = 1'b0;
		wr_addr = oi_q;
		route_wd = RW'(a);
		node_wd = NW'(na);
		if (state_q == ST_EX) begin
			route_we = wa;
			node_we = wna;
		end else if (state_q == ST_WT) begin
			wr_addr = ti_q;
			route_we = wb_route_en_q;
			node_we = wb_node_en_q;
			route_wd = RW'(wb_route_q);
			node_wd = NW'(wb_node_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			my_node_q <= 5'd1;
			timeout_q <= 32'd3000;
			done <= 1'b0;
			wb_route_en_q <= 1'b0;
			wb_node_en_q <= 1'b0;
			err_go_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MY_NODE: my_node_q <= cfg_wdata[4:0];
					CFG_TIMEOUT: timeout_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_take)
						state_q <= ST_RO;
				end
				ST_RO: state_q <= ST_RT;
				ST_RT: state_q <= ST_EX;
				ST_EX: begin
					done <= emit;
					wb_route_en_q <= wb;
					wb_node_en_q <= wnb;
					err_go_q <= err_go;
					state_q <= ST_WT;
				end
				ST_WT: begin
					state_q <= (err_go_q && err_mask_q != '0) ? ST_ER : ST_IDLE;
				end
				ST_ER: begin
					done <= 1'b1;
					if (rest_mask == '0)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			now_q <= now;
			snd_q <= sender;
			org_q <= origin;
			tgt_q <= target;
			rid_q <= request_id;
			oseq_q <= origin_seq;
			tseq_q <= target_seq;
			hop_q <= hop_count;
			life_q <= route_life;
			oi_q <= to_idx(origin);
			ti_q <= to_idx(target);
		end
		if (state_q == ST_RO) begin
			ro_q <= route_row_t'(route_rd);
			no_q <= node_row_t'(node_rd);
		end
		if (state_q == ST_RT) begin
			rt_q <= route_row_t'(route_rd);
			nt_q <= node_row_t'(node_rd);
		end
		if (state_q == ST_EX) begin
			wb_route_q <= b;
			wb_node_q <= nb;
			err_mask_q <= b.prec;
			err_seq_q <= b.seq;
			action <= e_act;
			next_node <= e_next;
			msg_origin <= e_org;
			msg_target <= e_tgt;
			msg_seq <= e_seq;
			msg_hops <= e_hops;
			msg_life <= e_life;
			last <= 1'b1;
		end
		if (state_q == ST_ER) begin
			err_mask_q <= rest_mask;
			action <= ACT_SEND_ERR;
			next_node <= low_idx + 5'd1;
			msg_origin <= '0;
			msg_target <= tgt_q;
			msg_seq <= err_seq_q;
			msg_hops <= '0;
			msg_life <= '0;
			last <= (rest_mask == '0);
		end
	end

endmodule
`default_nettype wire

// ===== sv/aodv_mem.sv =====
// Synchronous table memory with a registered read and per-entry written flags.
`default_nettype none
module aodv_mem #(
	parameter int W = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [W-1:0] rd_data,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input wire logic [W-1:0] wr_data
);

	logic [W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [W-1:0] data_q;
	logic hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q <= 1'b0;
		end else begin
			hit_q <= written_q[rd_addr];
			if (wr_en)
				written_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= mem[rd_addr];
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// An entry never written reads as its reset value of zero.
	assign rd_data = hit_q ? data_q : '0;

endmodule
`default_nettype wire
